@@ rtl/core/qphs_pkg.sv @@
// Shared types and constants of the quadratic-probe hash set.
// No dependencies; the request interface and the top level use it.
`default_nettype none

package qphs_pkg;

   localparam int KEY_W          = 32;
   localparam int OP_W           = 2;
   localparam int KIND_W         = 2;
   localparam int TABLE_SIZE_DEF = 2048;
   localparam int PROBE_QUAD     = 127;
   localparam int PROBE_LIN      = 19;
   localparam logic [KEY_W-1:0] MULT_RESET = 32'd2654435769;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_EMPTY  = 2'd0,
      KIND_TOMB   = 2'd1,
      KIND_FILLED = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_PROBE,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/qphs_req_if.sv @@
// Request channel of the hash set: valid/ready plus operation and key.
// Depends on qphs_pkg for field widths.
`default_nettype none

interface qphs_req_if;
   logic                        valid;
   logic                        ready;
   logic [qphs_pkg::OP_W-1:0]   operation;
   logic signed [qphs_pkg::KEY_W-1:0] key;

   modport source (output valid, output operation, output key, input ready);
   modport sink   (input valid, input operation, input key, output ready);
endinterface

`default_nettype wire

@@ rtl/core/qphs_rsp_if.sv @@
// Response channel of the hash set: valid/ready plus the one-bit answer.
// No package dependency.
`default_nettype none

interface qphs_rsp_if;
   logic valid;
   logic ready;
   logic answer;

   modport source (output valid, output answer, input ready);
   modport sink   (input valid, input answer, output ready);
endinterface

`default_nettype wire

@@ rtl/core/quadratic_probe_hash_set.sv @@
// Top level of the open-addressing hash set with quadratic probing.
// Depends on qphs_pkg, qphs_req_if and qphs_rsp_if.
//
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+---------------------------------
//   req      | in        | valid/ready   | operation[1:0], key[31:0] signed
//   rsp      | out       | valid/ready   | answer
//   csr      | in        | csr_wr_en     | csr_wr_data[31:0] (hash multiplier)
//
// A request is accepted, hashed by the multiply, reduced to its home-slot
// remainder (one byte per cycle through the shared reducer), walked along
// its probes (one slot read per cycle, read data registered) and answered.
// After reset the block sweeps the slot memory to empty, one slot per cycle,
// with req.ready low; csr writes are taken meanwhile.
// A response that is not taken holds in the output register; the next request
// is still accepted and walks its probes, then waits for the register to free.
`default_nettype none

module quadratic_probe_hash_set #(
   parameter int TABLE_SIZE = qphs_pkg::TABLE_SIZE_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   qphs_req_if.sink                         req,
   qphs_rsp_if.source                       rsp,
   input  wire logic                        csr_wr_en,
   input  wire logic [qphs_pkg::KEY_W-1:0]  csr_wr_data
);

   localparam int KW     = qphs_pkg::KEY_W;
   localparam int IW     = $clog2(TABLE_SIZE);
   localparam int CW     = $clog2(TABLE_SIZE + 1);
   localparam int BYTE_W = 8;
   localparam int BYTES  = KW / BYTE_W;
   localparam int BCW    = $clog2(BYTES);
   localparam int VW     = IW + BYTE_W;
   localparam int MW     = qphs_pkg::KIND_W + KW;
   // Probe offset grows by d(i) = 2*Q*i + Q + L; d itself grows by 2*Q.
   localparam int D0     = qphs_pkg::PROBE_QUAD + qphs_pkg::PROBE_LIN;
   localparam int DD     = 2 * qphs_pkg::PROBE_QUAD;
   localparam int DW     = $clog2(DD * TABLE_SIZE + D0 + 1);
   localparam logic [63:0] TWO_KW = 64'd1 << KW;

   localparam logic [IW:0]   N_V      = (IW+1)'(TABLE_SIZE);
   localparam logic [IW-1:0] D0_MOD   = IW'(D0 % TABLE_SIZE);
   localparam logic [IW-1:0] DD_MOD   = IW'(DD % TABLE_SIZE);
   localparam logic [IW-1:0] WRAP_MOD = IW'(TWO_KW % TABLE_SIZE);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_SIZE - 1);
   localparam logic [CW-1:0] ALL_CNT  = CW'(TABLE_SIZE);
   localparam logic [BCW-1:0] LAST_BYTE = BCW'(BYTES - 1);

   // Slot memory: kind in the top bits, key below.
   logic [MW-1:0] mem [TABLE_SIZE];

   qphs_pkg::state_type state_ff, state_in;
   logic [KW-1:0]  mult_ff, op_dummy_unused;
   logic [IW-1:0]  clr_idx_ff, clr_idx_in;
   logic [qphs_pkg::OP_W-1:0] op_ff, op_in;
   logic [KW-1:0]  key_ff, key_in;
   logic [KW-1:0]  h_ff, h_in;
   logic [KW-1:0]  hsh_ff, hsh_in;
   logic [BCW-1:0] byte_cnt_ff, byte_cnt_in;
   logic [IW-1:0]  r_ff, r_in;
   logic [KW-1:0]  s_ff, s_in;
   logic [DW-1:0]  d_ff, d_in;
   logic [IW-1:0]  dm_ff, dm_in;
   logic [CW-1:0]  iss_ff, iss_in;
   logic           chk_vld_ff, chk_vld_in;
   logic [IW-1:0]  chk_idx_ff, chk_idx_in;
   logic           chk_last_ff, chk_last_in;
   logic           phase_ff, phase_in;
   logic [IW-1:0]  tomb_idx_ff, tomb_idx_in;
   logic           res_ff, res_in;
   logic           rsp_vld_ff, rsp_vld_in;
   logic           ans_out_ff, ans_out_in;
   logic [MW-1:0]  rd_ff;

   logic [KW-1:0]  prod;
   logic [IW-1:0]  mod_rem;
   logic [IW-1:0]  r_next;
   logic [IW-1:0]  dm_next;
   logic [KW:0]    s_sum;

   logic           mem_we;
   logic [IW-1:0]  mem_wa;
   logic [MW-1:0]  mem_wd;

   logic [qphs_pkg::KIND_W-1:0] rd_kind;
   logic [KW-1:0]  rd_key;
   logic           is_empty, is_tomb, is_match;
   logic           done_now, ans_now;

   assign op_dummy_unused = '0;

   // ------------------------------------------------------------------
   // Hash multiply: low word of key times multiplier.
   // ------------------------------------------------------------------
   assign prod = key_ff * mult_ff;

   // ------------------------------------------------------------------
   // Shared reducer: fold the next byte of the hash into the remainder
   // modulo TABLE_SIZE by restoring subtraction, one bit per step.
   // ------------------------------------------------------------------
   always_comb begin
      logic [VW-1:0] v;
      v = {r_ff, hsh_ff[KW-1 -: BYTE_W]};
      for (int b = BYTE_W - 1; b >= 0; b--) begin
         if (v >= (VW'(TABLE_SIZE) << b)) begin
            v = v - (VW'(TABLE_SIZE) << b);
         end
      end
      mod_rem = v[IW-1:0];
   end

   // ------------------------------------------------------------------
   // Probe stepper: s tracks the 32-bit wrapped sum, r tracks s mod N.
   // Each 32-bit wrap removes 2^32 mod N from r.
   // ------------------------------------------------------------------
   always_comb begin
      logic [IW:0] t;
      logic [IW:0] u;
      s_sum = {1'b0, s_ff} + {1'b0, KW'(d_ff)};
      t = {1'b0, r_ff} + {1'b0, dm_ff};
      if (t >= N_V) begin
         t = t - N_V;
      end
      if (s_sum[KW]) begin
         if (t >= {1'b0, WRAP_MOD}) begin
            t = t - {1'b0, WRAP_MOD};
         end else begin
            t = t + N_V - {1'b0, WRAP_MOD};
         end
      end
      r_next = t[IW-1:0];
      u = {1'b0, dm_ff} + {1'b0, DD_MOD};
      if (u >= N_V) begin
         u = u - N_V;
      end
      dm_next = u[IW-1:0];
   end

   // ------------------------------------------------------------------
   // Probe check on the registered slot read.
   // ------------------------------------------------------------------
   assign rd_kind  = rd_ff[MW-1 -: qphs_pkg::KIND_W];
   assign rd_key   = rd_ff[KW-1:0];
   assign is_empty = (rd_kind == qphs_pkg::KIND_EMPTY);
   assign is_tomb  = (rd_kind == qphs_pkg::KIND_TOMB);
   assign is_match = (rd_kind == qphs_pkg::KIND_FILLED) && (rd_key == key_ff);

   // ------------------------------------------------------------------
   // Sequencer: next state, datapath loads and memory write.
   // ------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      clr_idx_in  = clr_idx_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      h_in        = h_ff;
      hsh_in      = hsh_ff;
      byte_cnt_in = byte_cnt_ff;
      r_in        = r_ff;
      s_in        = s_ff;
      d_in        = d_ff;
      dm_in       = dm_ff;
      iss_in      = iss_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      chk_last_in = chk_last_ff;
      phase_in    = phase_ff;
      tomb_idx_in = tomb_idx_ff;
      res_in      = res_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp.ready;
      ans_out_in  = ans_out_ff;
      mem_we      = 1'b0;
      mem_wa      = chk_idx_ff;
      mem_wd      = {qphs_pkg::KIND_FILLED, key_ff};
      done_now    = 1'b0;
      ans_now     = 1'b0;
      req.ready   = 1'b0;

      unique case (state_ff)
         qphs_pkg::ST_CLEAR: begin
            // Sweep every slot to empty.
            mem_we = 1'b1;
            mem_wa = clr_idx_ff;
            mem_wd = {qphs_pkg::KIND_EMPTY, KW'(0)};
            if (clr_idx_ff == LAST_IDX) begin
               state_in = qphs_pkg::ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + IW'(1);
            end
         end

         qphs_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               op_in  = req.operation;
               key_in = KW'(req.key);
               if (req.operation == qphs_pkg::OP_INSERT ||
                   req.operation == qphs_pkg::OP_REMOVE ||
                   req.operation == qphs_pkg::OP_LOOKUP) begin
                  state_in = qphs_pkg::ST_HASH;
               end else begin
                  // Unused code: no probe, answer 0.
                  res_in   = 1'b0;
                  state_in = qphs_pkg::ST_RESP;
               end
            end
         end

         qphs_pkg::ST_HASH: begin
            h_in        = prod;
            hsh_in      = prod;
            r_in        = '0;
            byte_cnt_in = '0;
            state_in    = qphs_pkg::ST_MOD;
         end

         qphs_pkg::ST_MOD: begin
            r_in        = mod_rem;
            hsh_in      = hsh_ff << BYTE_W;
            byte_cnt_in = byte_cnt_ff + BCW'(1);
            if (byte_cnt_ff == LAST_BYTE) begin
               // Home slot ready: seed the probe stepper.
               s_in     = h_ff;
               d_in     = DW'(D0);
               dm_in    = D0_MOD;
               iss_in   = '0;
               phase_in = 1'b0;
               state_in = qphs_pkg::ST_PROBE;
            end
         end

         qphs_pkg::ST_PROBE: begin
            // Issue the next probe address while checking the previous one.
            if (iss_ff != ALL_CNT) begin
               chk_vld_in  = 1'b1;
               chk_idx_in  = r_ff;
               chk_last_in = (iss_ff == LAST_CNT);
               iss_in      = iss_ff + CW'(1);
               s_in        = s_sum[KW-1:0];
               d_in        = d_ff + DW'(DD);
               dm_in       = dm_next;
               r_in        = r_next;
            end
            if (chk_vld_ff) begin
               unique case (op_ff)
                  qphs_pkg::OP_INSERT: begin
                     if (!phase_ff) begin
                        if (is_empty) begin
                           mem_we   = 1'b1;
                           done_now = 1'b1;
                           ans_now  = 1'b1;
                        end else if (is_tomb) begin
                           // Remember the tombstone; look further for the key.
                           phase_in    = 1'b1;
                           tomb_idx_in = chk_idx_ff;
                           if (chk_last_ff) begin
                              mem_we   = 1'b1;
                              done_now = 1'b1;
                              ans_now  = 1'b1;
                           end
                        end else if (is_match) begin
                           done_now = 1'b1;
                           ans_now  = 1'b1;
                        end else if (chk_last_ff) begin
                           done_now = 1'b1;
                           ans_now  = 1'b0;
                        end
                     end else begin
                        if (is_match) begin
                           done_now = 1'b1;
                           ans_now  = 1'b1;
                        end else if (is_empty || chk_last_ff) begin
                           mem_we   = 1'b1;
                           mem_wa   = tomb_idx_ff;
                           done_now = 1'b1;
                           ans_now  = 1'b1;
                        end
                     end
                  end
                  qphs_pkg::OP_REMOVE: begin
                     if (is_match) begin
                        mem_we   = 1'b1;
                        mem_wd   = {qphs_pkg::KIND_TOMB, key_ff};
                        done_now = 1'b1;
                        ans_now  = 1'b1;
                     end else if (is_empty || chk_last_ff) begin
                        done_now = 1'b1;
                        ans_now  = 1'b0;
                     end
                  end
                  default: begin
                     // Lookup.
                     if (is_match) begin
                        done_now = 1'b1;
                        ans_now  = 1'b1;
                     end else if (is_empty || chk_last_ff) begin
                        done_now = 1'b1;
                        ans_now  = 1'b0;
                     end
                  end
               endcase
            end
            if (done_now) begin
               res_in   = ans_now;
               state_in = qphs_pkg::ST_RESP;
            end
         end

         qphs_pkg::ST_RESP: begin
            // Hold until the output register is free.
            if (!rsp_vld_ff || rsp.ready) begin
               rsp_vld_in = 1'b1;
               ans_out_in = res_ff;
               state_in   = qphs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = qphs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp.valid  = rsp_vld_ff;
   assign rsp.answer = ans_out_ff;

   // ------------------------------------------------------------------
   // Control registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= qphs_pkg::ST_CLEAR;
         clr_idx_ff <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         mult_ff    <= qphs_pkg::MULT_RESET;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_wr_en) begin
            mult_ff <= csr_wr_data;
         end
      end
   end

   // ------------------------------------------------------------------
   // Payload registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in | op_dummy_unused;
      h_ff        <= h_in;
      hsh_ff      <= hsh_in;
      byte_cnt_ff <= byte_cnt_in;
      r_ff        <= r_in;
      s_ff        <= s_in;
      d_ff        <= d_in;
      dm_ff       <= dm_in;
      iss_ff      <= iss_in;
      chk_idx_ff  <= chk_idx_in;
      chk_last_ff <= chk_last_in;
      phase_ff    <= phase_in;
      tomb_idx_ff <= tomb_idx_in;
      res_ff      <= res_in;
      ans_out_ff  <= ans_out_in;
   end

   // ------------------------------------------------------------------
   // Slot memory: one write port, one registered read at the probe slot.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[r_ff];
   end

endmodule

`default_nettype wire
